// ----- sv/aahc_pkg.sv -----
// ----------------------------------------------------------------------------
// aahc_pkg
// Shared types and constants for the analog alarm hysteresis checker.
// ----------------------------------------------------------------------------
package aahc_pkg;

  // field widths
  localparam int unsigned LevelWidth = 32;
  localparam int unsigned BandWidth  = 31;
  localparam int unsigned StateWidth = 3;
  localparam int unsigned TripWidth  = 2;
  localparam int unsigned IndexWidth = 8;

  // alarm state codes
  localparam logic [StateWidth-1:0] ST_NORMAL       = 3'd0;
  localparam logic [StateWidth-1:0] ST_LOW_ALARM    = 3'd1;
  localparam logic [StateWidth-1:0] ST_LOW_CAUTION  = 3'd2;
  localparam logic [StateWidth-1:0] ST_HIGH_ALARM   = 3'd3;
  localparam logic [StateWidth-1:0] ST_HIGH_CAUTION = 3'd4;
  localparam logic [StateWidth-1:0] ST_FAILED       = 3'd5;

  // shutdown trip codes
  localparam logic [TripWidth-1:0] TRIP_NONE = 2'd0;
  localparam logic [TripWidth-1:0] TRIP_LOW  = 2'd1;
  localparam logic [TripWidth-1:0] TRIP_HIGH = 2'd2;

  // register indexes
  localparam logic [IndexWidth-1:0] REG_LOW_ALARM     = 8'd0;
  localparam logic [IndexWidth-1:0] REG_LOW_CAUTION   = 8'd1;
  localparam logic [IndexWidth-1:0] REG_HIGH_CAUTION  = 8'd2;
  localparam logic [IndexWidth-1:0] REG_HIGH_ALARM    = 8'd3;
  localparam logic [IndexWidth-1:0] REG_HYST_BAND     = 8'd4;
  localparam logic [IndexWidth-1:0] REG_LIMIT_ENABLE  = 8'd5;
  localparam logic [IndexWidth-1:0] REG_SHUTDN_ENABLE = 8'd6;
  localparam logic [IndexWidth-1:0] REG_POINT_DISABLE = 8'd7;

  // limit enable bit positions
  localparam int unsigned EN_LOW_ALARM    = 0;
  localparam int unsigned EN_LOW_CAUTION  = 1;
  localparam int unsigned EN_HIGH_ALARM   = 2;
  localparam int unsigned EN_HIGH_CAUTION = 3;

  // shutdown enable bit positions
  localparam int unsigned SD_LOW  = 0;
  localparam int unsigned SD_HIGH = 1;

  // configuration register reset values
  localparam logic [3:0] LIMIT_ENABLE_RESET  = 4'hF;
  localparam logic [1:0] SHUTDN_ENABLE_RESET = 2'b00;

  typedef struct packed {
    logic signed [LevelWidth-1:0] low_alarm_level;
    logic signed [LevelWidth-1:0] low_caution_level;
    logic signed [LevelWidth-1:0] high_caution_level;
    logic signed [LevelWidth-1:0] high_alarm_level;
    logic [BandWidth-1:0]         hysteresis_band;
    logic [3:0]                   limit_enable_mask;
    logic [1:0]                   shutdown_enable_mask;
    logic                         point_disable;
  } cfg_t;

  typedef struct packed {
    logic [StateWidth-1:0] alarm_state;
    logic [TripWidth-1:0]  shutdown_trip;
    logic                  display_request;
  } result_t;

endpackage

// ----- sv/analog_alarm_hysteresis_checker.sv -----
// ----------------------------------------------------------------------------
// analog_alarm_hysteresis_checker
// Analog limit alarm with deadband: input register, classifier, result register.
// ----------------------------------------------------------------------------
// Takes one sample per clock cycle when the result side keeps up. An accepted
// sample is held in the input register, classified against the four limits
// and the held alarm state, and loaded into the result outputs when the
// result side is not stalled.
// The held state is a single register updated in the same cycle a result is
// registered, so back-to-back samples each see the state left by the one
// before. A stalled result holds the pipeline; the input stalls only when both
// stages are full and the result is stalled. Configuration writes are always
// ready and should be done while no samples are in flight.
module analog_alarm_hysteresis_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  // sample channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [aahc_pkg::LevelWidth-1:0] sample_value,
  input  logic                                   sample_failed,
  input  logic                                   global_disable,
  input  logic                                   display_on,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [aahc_pkg::StateWidth-1:0]        alarm_state,
  output logic [aahc_pkg::TripWidth-1:0]         shutdown_trip,
  output logic                                   display_request,
  // configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [aahc_pkg::IndexWidth-1:0]        cfg_index,
  input  logic [aahc_pkg::LevelWidth-1:0]        cfg_data
);

  aahc_pkg::cfg_t cfg;

  logic                                   stage_valid;
  logic signed [aahc_pkg::LevelWidth-1:0] stage_value;
  logic                                   stage_failed;
  logic                                   stage_gdis;
  logic                                   stage_disp;

  logic [aahc_pkg::StateWidth-1:0] held_state;
  aahc_pkg::result_t               result;
  logic                            advance;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_alarm_level      <= '0;
      cfg.low_caution_level    <= '0;
      cfg.high_caution_level   <= '0;
      cfg.high_alarm_level     <= '0;
      cfg.hysteresis_band      <= '0;
      cfg.limit_enable_mask    <= aahc_pkg::LIMIT_ENABLE_RESET;
      cfg.shutdown_enable_mask <= aahc_pkg::SHUTDN_ENABLE_RESET;
      cfg.point_disable        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        aahc_pkg::REG_LOW_ALARM:     cfg.low_alarm_level    <= $signed(cfg_data);
        aahc_pkg::REG_LOW_CAUTION:   cfg.low_caution_level  <= $signed(cfg_data);
        aahc_pkg::REG_HIGH_CAUTION:  cfg.high_caution_level <= $signed(cfg_data);
        aahc_pkg::REG_HIGH_ALARM:    cfg.high_alarm_level   <= $signed(cfg_data);
        aahc_pkg::REG_HYST_BAND:
          cfg.hysteresis_band <= cfg_data[aahc_pkg::BandWidth-1:0];
        aahc_pkg::REG_LIMIT_ENABLE:  cfg.limit_enable_mask    <= cfg_data[3:0];
        aahc_pkg::REG_SHUTDN_ENABLE: cfg.shutdown_enable_mask <= cfg_data[1:0];
        aahc_pkg::REG_POINT_DISABLE: cfg.point_disable        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign advance  = stage_valid && (!out_valid || !out_stall);
  assign in_stall = stage_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_value  <= sample_value;
      stage_failed <= sample_failed;
      stage_gdis   <= global_disable;
      stage_disp   <= display_on;
    end
  end

  aahc_classify u_classify (
    .sample_value   (stage_value),
    .sample_failed  (stage_failed),
    .global_disable (stage_gdis),
    .display_on     (stage_disp),
    .cfg            (cfg),
    .held_state     (held_state),
    .result         (result)
  );

  // held state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      held_state <= aahc_pkg::ST_NORMAL;
      out_valid  <= 1'b0;
    end else begin
      if (advance) begin
        held_state <= result.alarm_state;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      alarm_state     <= result.alarm_state;
      shutdown_trip   <= result.shutdown_trip;
      display_request <= result.display_request;
    end
  end

endmodule

// ----- sv/aahc_classify.sv -----
// ----------------------------------------------------------------------------
// aahc_classify
// Limit classification of one sample against the held state with deadband.
// ----------------------------------------------------------------------------
module aahc_classify (
  input  logic signed [aahc_pkg::LevelWidth-1:0] sample_value,
  input  logic                                   sample_failed,
  input  logic                                   global_disable,
  input  logic                                   display_on,
  input  aahc_pkg::cfg_t                         cfg,
  input  logic [aahc_pkg::StateWidth-1:0]        held_state,
  output aahc_pkg::result_t                      result
);

  localparam int unsigned WideWidth = aahc_pkg::LevelWidth + 1;

  logic signed [WideWidth-1:0] pv;
  logic signed [WideWidth-1:0] band;
  logic signed [WideWidth-1:0] la;
  logic signed [WideWidth-1:0] lc;
  logic signed [WideWidth-1:0] ha;
  logic signed [WideWidth-1:0] hc;
  logic hit_la;
  logic hit_lc;
  logic hit_ha;
  logic hit_hc;

  // widen to one extra bit so the deadband never wraps
  assign pv   = WideWidth'(sample_value);
  assign band = $signed({2'b00, cfg.hysteresis_band});

  // only the limit of the held state gets the deadband
  always_comb begin
    la = WideWidth'(cfg.low_alarm_level);
    lc = WideWidth'(cfg.low_caution_level);
    ha = WideWidth'(cfg.high_alarm_level);
    hc = WideWidth'(cfg.high_caution_level);
    case (held_state)
      aahc_pkg::ST_HIGH_ALARM:   ha = ha - band;
      aahc_pkg::ST_LOW_ALARM:    la = la + band;
      aahc_pkg::ST_HIGH_CAUTION: hc = hc - band;
      aahc_pkg::ST_LOW_CAUTION:  lc = lc + band;
      default: ;
    endcase
  end

  // gated limit compares
  assign hit_la = cfg.limit_enable_mask[aahc_pkg::EN_LOW_ALARM]    && (pv <= la);
  assign hit_lc = cfg.limit_enable_mask[aahc_pkg::EN_LOW_CAUTION]  && (pv <= lc);
  assign hit_ha = cfg.limit_enable_mask[aahc_pkg::EN_HIGH_ALARM]   && (pv >= ha);
  assign hit_hc = cfg.limit_enable_mask[aahc_pkg::EN_HIGH_CAUTION] && (pv >= hc);

  // priority select: failed, disabled, then low alarm down to high caution
  always_comb begin
    result.alarm_state     = aahc_pkg::ST_NORMAL;
    result.shutdown_trip   = aahc_pkg::TRIP_NONE;
    result.display_request = 1'b0;
    if (sample_failed) begin
      result.alarm_state = aahc_pkg::ST_FAILED;
    end else if (cfg.point_disable || global_disable) begin
      result.alarm_state = aahc_pkg::ST_NORMAL;
    end else begin
      if (hit_la) begin
        result.alarm_state = aahc_pkg::ST_LOW_ALARM;
        if (cfg.shutdown_enable_mask[aahc_pkg::SD_LOW]) begin
          result.shutdown_trip = aahc_pkg::TRIP_LOW;
        end
      end else if (hit_lc) begin
        result.alarm_state = aahc_pkg::ST_LOW_CAUTION;
      end else if (hit_ha) begin
        result.alarm_state = aahc_pkg::ST_HIGH_ALARM;
        if (cfg.shutdown_enable_mask[aahc_pkg::SD_HIGH]) begin
          result.shutdown_trip = aahc_pkg::TRIP_HIGH;
        end
      end else if (hit_hc) begin
        result.alarm_state = aahc_pkg::ST_HIGH_CAUTION;
      end
      // newly left normal while nobody is looking
      result.display_request = !display_on &&
                               (held_state == aahc_pkg::ST_NORMAL) &&
                               (result.alarm_state != aahc_pkg::ST_NORMAL);
    end
  end

endmodule

// ----- sv/aahc_checker.sv -----
// ----------------------------------------------------------------------------
// aahc_checker
// Port-level assertions for the analog alarm hysteresis checker.
// ----------------------------------------------------------------------------
module aahc_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_stall,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic [aahc_pkg::StateWidth-1:0]        alarm_state,
  input logic [aahc_pkg::TripWidth-1:0]         shutdown_trip,
  input logic                                   display_request
);

  // no result may be pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result transaction holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(alarm_state) &&
      $stable(shutdown_trip) && $stable(display_request))
    else $error("stalled result changed");

  // a shutdown trip only comes with the matching alarm state
  a_trip: assert property (@(posedge clk) disable iff (rst)
    out_valid && (shutdown_trip != aahc_pkg::TRIP_NONE) |->
      (shutdown_trip == aahc_pkg::TRIP_LOW && alarm_state == aahc_pkg::ST_LOW_ALARM) ||
      (shutdown_trip == aahc_pkg::TRIP_HIGH && alarm_state == aahc_pkg::ST_HIGH_ALARM))
    else $error("shutdown trip without matching alarm");

  // a display request only comes with a limit state
  a_disp: assert property (@(posedge clk) disable iff (rst)
    out_valid && display_request |->
      alarm_state != aahc_pkg::ST_NORMAL && alarm_state != aahc_pkg::ST_FAILED)
    else $error("display request without a limit state");

  // the input stalls only with a result waiting on a stalled output
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with the output free");

endmodule

bind analog_alarm_hysteresis_checker aahc_checker u_aahc_checker (
  .clk             (clk),
  .rst             (rst),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .alarm_state     (alarm_state),
  .shutdown_trip   (shutdown_trip),
  .display_request (display_request)
);

// ----- tb/analog_alarm_hysteresis_checker_test.sv -----
// ----------------------------------------------------------------------------
// analog_alarm_hysteresis_checker_test
// Self-checking bench for the analog limit alarm with deadband.
// ----------------------------------------------------------------------------
// A short table of directed samples and register writes comes first: the
// field extremes, failed and disabled points, shutdown trips, deadband hold on
// every limit, widened limits pushed past the 32-bit range, and writes to
// unused indexes or with bits above a register's width. Random limit settings
// follow, with samples clustered around the limits. Each result is compared
// with a local prediction of alarm state, trip and display request, while
// both channels idle and stall in random bursts.
module analog_alarm_hysteresis_checker_test;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 60;
  localparam int NumPhases  = 8;
  localparam int PhaseItems = 60;
  localparam int MinLevel   = 32'sh8000_0000;
  localparam int MaxLevel   = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [aahc_pkg::LevelWidth-1:0] value;
    logic                                   failed;
    logic                                   all_disabled;
    logic                                   shown;
  } sample_t;

  typedef struct packed {
    logic                             is_write;
    logic [aahc_pkg::IndexWidth-1:0]  index;
    logic [aahc_pkg::LevelWidth-1:0]  data;
    sample_t                          smp;
    logic                             typed;
    aahc_pkg::result_t                want;
  } step_t;

  // dut connections, all inputs known from time zero
  logic                                   clk            = 1'b0;
  logic                                   rst            = 1'b1;
  logic                                   in_valid       = 1'b0;
  logic                                   in_stall;
  logic signed [aahc_pkg::LevelWidth-1:0] sample_value   = '0;
  logic                                   sample_failed  = 1'b0;
  logic                                   global_disable = 1'b0;
  logic                                   display_on     = 1'b0;
  logic                                   out_valid;
  logic                                   out_stall      = 1'b0;
  logic [aahc_pkg::StateWidth-1:0]        alarm_state;
  logic [aahc_pkg::TripWidth-1:0]         shutdown_trip;
  logic                                   display_request;
  logic                                   cfg_valid      = 1'b0;
  logic                                   cfg_ready;
  logic [aahc_pkg::IndexWidth-1:0]        cfg_index      = '0;
  logic [aahc_pkg::LevelWidth-1:0]        cfg_data       = '0;

  // predictor state and bookkeeping
  aahc_pkg::cfg_t                  model_cfg;
  logic [aahc_pkg::StateWidth-1:0] prior_state;
  aahc_pkg::result_t               expected_alarms[$];
  int                              idle_pct        = 0;
  bit                              hold_request    = 1'b0;
  int                              failures        = 0;
  int                              samples_sent    = 0;
  int                              results_checked = 0;
  int                              cycle_count     = 0;
  int                              near_level[4];
  int unsigned                     near_span       = 16;

  analog_alarm_hysteresis_checker u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .sample_value    (sample_value),
    .sample_failed   (sample_failed),
    .global_disable  (global_disable),
    .display_on      (display_on),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .alarm_state     (alarm_state),
    .shutdown_trip   (shutdown_trip),
    .display_request (display_request),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $error("run stuck after %0d cycles, %0d results outstanding", CycleLimit,
             expected_alarms.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int q16(int units);
    return units * 65536;
  endfunction

  function automatic int extreme_level();
    case ($urandom_range(4))
      0: return MinLevel;
      1: return MinLevel + 1;
      2: return 0;
      3: return MaxLevel - 1;
      default: return MaxLevel;
    endcase
  endfunction

  // classify one sample against the limits and advance the held state
  function automatic aahc_pkg::result_t classify_sample(sample_t s);
    logic signed [aahc_pkg::LevelWidth:0] pv, la, lc, hc, ha, band;
    aahc_pkg::result_t r;
    r = '0;
    r.alarm_state   = aahc_pkg::ST_NORMAL;
    r.shutdown_trip = aahc_pkg::TRIP_NONE;
    if (s.failed) begin
      r.alarm_state = aahc_pkg::ST_FAILED;
    end else if (model_cfg.point_disable || s.all_disabled) begin
      r.alarm_state = aahc_pkg::ST_NORMAL;
    end else begin
      // one extra bit so a widened limit never wraps
      pv   = {s.value[aahc_pkg::LevelWidth-1], s.value};
      la   = {model_cfg.low_alarm_level[aahc_pkg::LevelWidth-1],
              model_cfg.low_alarm_level};
      lc   = {model_cfg.low_caution_level[aahc_pkg::LevelWidth-1],
              model_cfg.low_caution_level};
      hc   = {model_cfg.high_caution_level[aahc_pkg::LevelWidth-1],
              model_cfg.high_caution_level};
      ha   = {model_cfg.high_alarm_level[aahc_pkg::LevelWidth-1],
              model_cfg.high_alarm_level};
      band = {2'b00, model_cfg.hysteresis_band};
      // deadband on the limit of the state held last
      case (prior_state)
        aahc_pkg::ST_HIGH_ALARM:   ha = ha - band;
        aahc_pkg::ST_LOW_ALARM:    la = la + band;
        aahc_pkg::ST_HIGH_CAUTION: hc = hc - band;
        aahc_pkg::ST_LOW_CAUTION:  lc = lc + band;
        default: ;
      endcase
      // priority: low alarm, low caution, high alarm, high caution
      if (model_cfg.limit_enable_mask[aahc_pkg::EN_LOW_ALARM] && pv <= la) begin
        r.alarm_state = aahc_pkg::ST_LOW_ALARM;
        if (model_cfg.shutdown_enable_mask[aahc_pkg::SD_LOW])
          r.shutdown_trip = aahc_pkg::TRIP_LOW;
      end else if (model_cfg.limit_enable_mask[aahc_pkg::EN_LOW_CAUTION] && pv <= lc) begin
        r.alarm_state = aahc_pkg::ST_LOW_CAUTION;
      end else if (model_cfg.limit_enable_mask[aahc_pkg::EN_HIGH_ALARM] && pv >= ha) begin
        r.alarm_state = aahc_pkg::ST_HIGH_ALARM;
        if (model_cfg.shutdown_enable_mask[aahc_pkg::SD_HIGH])
          r.shutdown_trip = aahc_pkg::TRIP_HIGH;
      end else if (model_cfg.limit_enable_mask[aahc_pkg::EN_HIGH_CAUTION] && pv >= hc) begin
        r.alarm_state = aahc_pkg::ST_HIGH_CAUTION;
      end
      r.display_request = !s.shown && r.alarm_state != aahc_pkg::ST_NORMAL &&
                          prior_state == aahc_pkg::ST_NORMAL;
    end
    prior_state = r.alarm_state;
    return r;
  endfunction

  // register write as the block sees it, upper bits dropped
  function automatic void apply_reg_write(logic [aahc_pkg::IndexWidth-1:0] idx,
                                          logic [aahc_pkg::LevelWidth-1:0] d);
    case (idx)
      aahc_pkg::REG_LOW_ALARM:     model_cfg.low_alarm_level      = d;
      aahc_pkg::REG_LOW_CAUTION:   model_cfg.low_caution_level    = d;
      aahc_pkg::REG_HIGH_CAUTION:  model_cfg.high_caution_level   = d;
      aahc_pkg::REG_HIGH_ALARM:    model_cfg.high_alarm_level     = d;
      aahc_pkg::REG_HYST_BAND:
        model_cfg.hysteresis_band = d[aahc_pkg::BandWidth-1:0];
      aahc_pkg::REG_LIMIT_ENABLE:  model_cfg.limit_enable_mask    = d[3:0];
      aahc_pkg::REG_SHUTDN_ENABLE: model_cfg.shutdown_enable_mask = d[1:0];
      aahc_pkg::REG_POINT_DISABLE: model_cfg.point_disable        = d[0];
      default: ;
    endcase
  endfunction

  // directed table rows
  function automatic step_t write_row(logic [aahc_pkg::IndexWidth-1:0] idx,
                                      logic [aahc_pkg::LevelWidth-1:0] d);
    step_t r;
    r = '0;
    r.is_write = 1'b1;
    r.index    = idx;
    r.data     = d;
    return r;
  endfunction

  function automatic step_t sample_row(int v, logic f, logic dis, logic sh);
    step_t r;
    r = '0;
    r.smp.value        = v;
    r.smp.failed       = f;
    r.smp.all_disabled = dis;
    r.smp.shown        = sh;
    return r;
  endfunction

  function automatic step_t known_row(int v, logic f, logic dis, logic sh,
                                      logic [aahc_pkg::StateWidth-1:0] st,
                                      logic [aahc_pkg::TripWidth-1:0] tr, logic rq);
    step_t r;
    r = sample_row(v, f, dis, sh);
    r.typed                = 1'b1;
    r.want.alarm_state     = st;
    r.want.shutdown_trip   = tr;
    r.want.display_request = rq;
    return r;
  endfunction

  // random sample, mostly close to one of the limits
  function automatic sample_t make_sample();
    sample_t s;
    int unsigned pick;
    longint v;
    pick = $urandom_range(99);
    if (pick < 10) begin
      v = longint'($signed($urandom()));
    end else if (pick < 16) begin
      v = longint'(extreme_level());
    end else begin
      v = longint'(near_level[$urandom_range(3)]) +
          longint'($urandom_range(2 * near_span)) - longint'(near_span);
    end
    if (v > longint'(MaxLevel)) v = longint'(MaxLevel);
    if (v < longint'(MinLevel)) v = longint'(MinLevel);
    s.value        = v[aahc_pkg::LevelWidth-1:0];
    s.failed       = $urandom_range(99) < 6;
    s.all_disabled = $urandom_range(99) < 6;
    s.shown        = 1'($urandom_range(1));
    return s;
  endfunction

  // stop offering samples and wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_alarms.size() != 0) @(posedge clk);
  endtask

  // one register write transaction; valid stays up for a following write
  task automatic write_reg(logic [aahc_pkg::IndexWidth-1:0] idx,
                           logic [aahc_pkg::LevelWidth-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    apply_reg_write(idx, d);
  endtask

  // one sample transaction, with an optional idle burst ahead of it
  task automatic send_sample(sample_t s, logic typed, aahc_pkg::result_t want);
    aahc_pkg::result_t predicted;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    sample_value   <= s.value;
    sample_failed  <= s.failed;
    global_disable <= s.all_disabled;
    display_on     <= s.shown;
    do @(posedge clk); while (in_stall);
    predicted = classify_sample(s);
    expected_alarms.push_back(typed ? want : predicted);
    samples_sent++;
  endtask

  // random limit setting for one phase
  task automatic program_phase(int mode);
    int lvl[4];
    int center;
    int spacing;
    int unsigned band;
    logic [3:0] en_mask;
    if (mode == 1) begin
      foreach (lvl[i]) lvl[i] = $urandom();
      band = $urandom_range(32'h7FFF_FFFF);
    end else if (mode == 2) begin
      foreach (lvl[i]) lvl[i] = extreme_level();
      band = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h0;
    end else begin
      // ordered limits, wide or tight around a random center
      center  = int'($urandom()) >>> 2;
      spacing = (mode == 0) ? $urandom_range(1 << 22, 1) : $urandom_range(64, 1);
      lvl[0]  = center - 2 * spacing;
      lvl[1]  = center - spacing;
      lvl[2]  = center + spacing;
      lvl[3]  = center + 2 * spacing;
      band    = $urandom_range(2 * spacing);
    end
    en_mask = (mode != 1 && $urandom_range(1)) ? 4'hF : 4'($urandom_range(15));
    near_level = lvl;
    near_span  = ((band > 32'h4000_0000) ? 32'h4000_0000 : band) + 16;
    write_reg(aahc_pkg::REG_LOW_ALARM, lvl[0]);
    write_reg(aahc_pkg::REG_LOW_CAUTION, lvl[1]);
    write_reg(aahc_pkg::REG_HIGH_CAUTION, lvl[2]);
    write_reg(aahc_pkg::REG_HIGH_ALARM, lvl[3]);
    write_reg(aahc_pkg::REG_HYST_BAND, band | ($urandom() & 32'h8000_0000));
    write_reg(aahc_pkg::REG_LIMIT_ENABLE, ($urandom() & 32'hFFFF_FFF0) | en_mask);
    write_reg(aahc_pkg::REG_SHUTDN_ENABLE,
              ($urandom() & 32'hFFFF_FFFC) | $urandom_range(3));
    write_reg(aahc_pkg::REG_POINT_DISABLE,
              ($urandom() & 32'hFFFF_FFFE) | 32'($urandom_range(5) == 0));
    // unused indexes must leave every register alone
    if ($urandom_range(2) == 0)
      write_reg(aahc_pkg::IndexWidth'($urandom_range(255,
                aahc_pkg::REG_POINT_DISABLE + 1)), $urandom());
  endtask

  // result side: check each transaction, then pick the stall for the next cycle
  initial begin : result_checker
    aahc_pkg::result_t got;
    aahc_pkg::result_t want;
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.alarm_state     = alarm_state;
        got.shutdown_trip   = shutdown_trip;
        got.display_request = display_request;
        if (expected_alarms.size() == 0) begin
          $error("result with nothing expected: state %0d trip %0d request %0d",
                 got.alarm_state, got.shutdown_trip, got.display_request);
          failures++;
        end else begin
          want = expected_alarms.pop_front();
          results_checked++;
          if (got.alarm_state !== want.alarm_state) begin
            $error("alarm_state: expected %0d, got %0d", want.alarm_state,
                   got.alarm_state);
            failures++;
          end
          if (got.shutdown_trip !== want.shutdown_trip) begin
            $error("shutdown_trip: expected %0d, got %0d", want.shutdown_trip,
                   got.shutdown_trip);
            failures++;
          end
          if (got.display_request !== want.display_request) begin
            $error("display_request: expected %0d, got %0d", want.display_request,
                   got.display_request);
            failures++;
          end
        end
      end
      // long hold-off on request, otherwise random stall bursts
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HoldCycles;
      end else if (stall_left == 0 && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        stall_left = $urandom_range(17, 1);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus: directed table, then random phases
  initial begin : stimulus
    step_t directed[$];
    aahc_pkg::result_t unused;
    unused = '0;

    // reset values, extremes, failed and disabled samples
    directed.push_back(known_row(MaxLevel, 1'b1, 1'b0, 1'b0, aahc_pkg::ST_FAILED,
                                 aahc_pkg::TRIP_NONE, 1'b0));
    directed.push_back(known_row(MinLevel, 1'b0, 1'b1, 1'b0, aahc_pkg::ST_NORMAL,
                                 aahc_pkg::TRIP_NONE, 1'b0));
    directed.push_back(known_row(MaxLevel, 1'b0, 1'b0, 1'b0, aahc_pkg::ST_HIGH_ALARM,
                                 aahc_pkg::TRIP_NONE, 1'b1));
    directed.push_back(known_row(MinLevel, 1'b0, 1'b0, 1'b0, aahc_pkg::ST_LOW_ALARM,
                                 aahc_pkg::TRIP_NONE, 1'b0));
    // shutdown enables with junk upper bits, writes to unused indexes
    directed.push_back(write_row(aahc_pkg::REG_SHUTDN_ENABLE, 32'hFFFF_FFFF));
    directed.push_back(write_row(aahc_pkg::REG_POINT_DISABLE + 8'd1, 32'h1234_5678));
    directed.push_back(write_row(8'hFF, 32'hFFFF_FFFF));
    directed.push_back(known_row(MinLevel, 1'b0, 1'b0, 1'b1, aahc_pkg::ST_LOW_ALARM,
                                 aahc_pkg::TRIP_LOW, 1'b0));
    directed.push_back(known_row(MaxLevel, 1'b0, 1'b0, 1'b1, aahc_pkg::ST_HIGH_ALARM,
                                 aahc_pkg::TRIP_HIGH, 1'b0));
    directed.push_back(known_row(0, 1'b0, 1'b0, 1'b0, aahc_pkg::ST_LOW_ALARM,
                                 aahc_pkg::TRIP_LOW, 1'b0));
    // spaced limits with a deadband, walk through every state
    directed.push_back(write_row(aahc_pkg::REG_LOW_ALARM, q16(-100)));
    directed.push_back(write_row(aahc_pkg::REG_LOW_CAUTION, q16(-50)));
    directed.push_back(write_row(aahc_pkg::REG_HIGH_CAUTION, q16(50)));
    directed.push_back(write_row(aahc_pkg::REG_HIGH_ALARM, q16(100)));
    directed.push_back(write_row(aahc_pkg::REG_HYST_BAND, q16(10)));
    directed.push_back(write_row(aahc_pkg::REG_SHUTDN_ENABLE, '0));
    directed.push_back(sample_row(q16(0), 1'b0, 1'b0, 1'b0));
    directed.push_back(sample_row(q16(95), 1'b0, 1'b0, 1'b0));
    directed.push_back(sample_row(q16(105), 1'b0, 1'b0, 1'b0));
    directed.push_back(sample_row(q16(95), 1'b0, 1'b0, 1'b0));
    directed.push_back(sample_row(q16(85), 1'b0, 1'b0, 1'b0));
    directed.push_back(sample_row(q16(45), 1'b0, 1'b0, 1'b0));
    directed.push_back(sample_row(q16(35), 1'b0, 1'b0, 1'b0));
    directed.push_back(sample_row(q16(-55), 1'b0, 1'b0, 1'b1));
    directed.push_back(sample_row(q16(-45), 1'b0, 1'b0, 1'b0));
    directed.push_back(sample_row(q16(-105), 1'b0, 1'b0, 1'b0));
    directed.push_back(sample_row(q16(-95), 1'b0, 1'b0, 1'b0));
    directed.push_back(sample_row(q16(-95), 1'b1, 1'b0, 1'b0));
    // held failed state widens nothing
    directed.push_back(sample_row(q16(-95), 1'b0, 1'b0, 1'b0));
    // widened limits beyond the 32-bit range must not wrap
    directed.push_back(write_row(aahc_pkg::REG_LIMIT_ENABLE, 32'hFFFF_FFF4));
    directed.push_back(write_row(aahc_pkg::REG_HIGH_ALARM, MinLevel + 1));
    directed.push_back(write_row(aahc_pkg::REG_HYST_BAND, 32'hFFFF_FFFF));
    directed.push_back(sample_row(MinLevel + 1, 1'b0, 1'b0, 1'b0));
    directed.push_back(sample_row(MinLevel, 1'b0, 1'b0, 1'b0));
    directed.push_back(write_row(aahc_pkg::REG_LIMIT_ENABLE, 32'h0000_0001));
    directed.push_back(write_row(aahc_pkg::REG_LOW_ALARM, MaxLevel - 1));
    directed.push_back(sample_row(MaxLevel - 1, 1'b0, 1'b0, 1'b0));
    directed.push_back(sample_row(MaxLevel, 1'b0, 1'b0, 1'b0));
    // point disable forces normal
    directed.push_back(write_row(aahc_pkg::REG_POINT_DISABLE, 32'h0000_0003));
    directed.push_back(known_row(q16(0), 1'b0, 1'b0, 1'b0, aahc_pkg::ST_NORMAL,
                                 aahc_pkg::TRIP_NONE, 1'b0));

    // predictor starts from the reset values
    model_cfg                      = '0;
    model_cfg.limit_enable_mask    = aahc_pkg::LIMIT_ENABLE_RESET;
    model_cfg.shutdown_enable_mask = aahc_pkg::SHUTDN_ENABLE_RESET;
    prior_state                    = aahc_pkg::ST_NORMAL;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 20;
    foreach (directed[i]) begin
      if (directed[i].is_write) begin
        wait_drained();
        write_reg(directed[i].index, directed[i].data);
      end else begin
        if (cfg_valid) cfg_valid <= 1'b0;
        send_sample(directed[i].smp, directed[i].typed, directed[i].want);
      end
    end

    for (int phase = 0; phase < NumPhases; phase++) begin
      wait_drained();
      if (phase >= NumPhases - 2) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      program_phase(phase % 4);
      cfg_valid <= 1'b0;
      for (int k = 0; k < PhaseItems; k++) begin
        // receiver holds off while samples keep coming
        if (phase == 2 && k == 5) hold_request = 1'b1;
        // sender pauses until the pipeline is empty
        if (phase == 4 && k == 30) wait_drained();
        send_sample(make_sample(), 1'b0, unused);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (expected_alarms.size() != 0) begin
      $error("%0d expected results never arrived", expected_alarms.size());
      failures++;
    end
    $display("covered %0d samples over %0d limit settings plus the directed table,",
             samples_sent, NumPhases);
    $display("%0d results compared, %0d mismatches", results_checked, failures);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
